@@ hdl/repeated_write_window_tracker_defines.svh @@
// ---------------------------------------------------------------------------
// Repeated-write window tracker: assertion macros
// Shared assertion macros; defining ASSERT_OFF compiles them away.
// ---------------------------------------------------------------------------
`ifndef REPEATED_WRITE_WINDOW_TRACKER_DEFINES_SVH
`define REPEATED_WRITE_WINDOW_TRACKER_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked assertion that is switched off while reset is high.
`define RWWT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked assertion that is checked during reset as well.
`define RWWT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RWWT_ASSERT(label, clk, rst, prop, msg)
`define RWWT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ hdl/rwwt_pkg.sv @@
// ---------------------------------------------------------------------------
// Repeated-write window tracker package
// Widths and the per-cell status word shared by the tracker modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rwwt_pkg;

  // Width of an observed write address.
  localparam int ADDR_W = 64;

  // Width of the count fields carried by a result word.
  localparam int OUT_W = 32;

  // Status that each cell of the chain reports to the control logic.
  typedef struct packed {
    logic valid;  // the cell holds a tracked address
    logic match;  // the held address equals the incoming address
  } slot_status_t;

endpackage

@@ hdl/rwwt_cell.sv @@
// ---------------------------------------------------------------------------
// Repeated-write window tracker cell
// One position of the age chain: holds an address and its write count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rwwt_cell #(
  parameter int COUNT_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic [rwwt_pkg::ADDR_W-1:0] probe,
  input  logic                       link_valid,
  input  logic [rwwt_pkg::ADDR_W-1:0] link_address,
  input  logic [COUNT_BITS-1:0]      link_count,
  output rwwt_pkg::slot_status_t     status,
  output logic [rwwt_pkg::ADDR_W-1:0] slot_address,
  output logic [COUNT_BITS-1:0]      slot_count
);

  import rwwt_pkg::*;

  logic slot_valid;

  // On every accepted word the cell takes over the entry of its upstream
  // neighbour, so the position in the chain is the entry's age.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (advance) begin
      slot_valid <= link_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      slot_address <= link_address;
      slot_count   <= link_count;
    end
  end

  always_comb begin
    status.valid = slot_valid;
    status.match = slot_valid && (slot_address == probe);
  end

endmodule

@@ hdl/repeated_write_window_tracker.sv @@
// ---------------------------------------------------------------------------
// Repeated-write window tracker
// Counts repeated writes to recently written addresses over a sliding window.
// ---------------------------------------------------------------------------
// The tracker takes one write address per input word and returns one result
// word for it: whether the address was still being tracked, its run count
// after this write, the largest run count seen by any repeated write since
// reset, and the number of writes seen since reset. All counts saturate at
// 2**COUNT_BITS - 1 and the result ports carry their low 32 bits. An address
// stays tracked while no more than WINDOW-1 other writes come between two
// writes to it. Throughput is one word per clock cycle while no result is
// stalled; the result is registered, so it appears the cycle after the word
// is taken. The cycle is set by the parallel address compare across all
// WINDOW cells together with the count increment and maximum compare that
// follow it. A new word is taken while the previous result waits, as long
// as that result is being taken in the same cycle. After reset nothing is
// tracked and all totals are zero; no clearing pass is needed.
`timescale 1ns / 1ps
`include "repeated_write_window_tracker_defines.svh"

module repeated_write_window_tracker #(
  parameter int WINDOW     = 4,
  parameter int COUNT_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rwwt_pkg::ADDR_W-1:0] write_address,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        address_hit,
  output logic [rwwt_pkg::OUT_W-1:0]  run_count,
  output logic [rwwt_pkg::OUT_W-1:0]  max_run,
  output logic [rwwt_pkg::OUT_W-1:0]  write_total
);

  import rwwt_pkg::*;

  // Chain state. Cell k holds the entry with k writes of age, i.e. a
  // remaining life of WINDOW-1-k; the last cell's entry falls off the end.
  slot_status_t           status       [WINDOW];
  logic [ADDR_W-1:0]      cell_address [WINDOW];
  logic [COUNT_BITS-1:0]  cell_count   [WINDOW];
  logic                   link_valid   [WINDOW];
  logic [ADDR_W-1:0]      link_address [WINDOW];
  logic [COUNT_BITS-1:0]  link_count   [WINDOW];

  logic [COUNT_BITS-1:0]  max_run_reg;
  logic [COUNT_BITS-1:0]  write_counter;
  logic [COUNT_BITS-1:0]  max_run_next;
  logic [COUNT_BITS-1:0]  write_counter_next;

  logic                   accept;
  logic                   hit;
  logic [COUNT_BITS-1:0]  hit_count;
  logic [COUNT_BITS-1:0]  run_next;
  logic [WINDOW-1:0]      match_vec;

  // A word is taken unless a finished result is still held and stalled.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Compare the incoming address against every cell at once. At most one
  // cell can match, so the hit count is an OR of the masked counts.
  always_comb begin
    hit       = 1'b0;
    hit_count = '0;
    for (int k = 0; k < WINDOW; k++) begin
      match_vec[k] = status[k].match;
      hit          = hit | status[k].match;
      hit_count    = hit_count | (status[k].match ? cell_count[k] : '0);
    end
  end

  // A repeated write carries its incremented count back to the head of the
  // chain; a first write starts a new entry with a count of one.
  always_comb begin
    if (hit) begin
      run_next = (hit_count == '1) ? hit_count : hit_count + 1'b1;
    end else begin
      run_next = COUNT_BITS'(1);
    end
    if (hit && (run_next > max_run_reg)) begin
      max_run_next = run_next;
    end else begin
      max_run_next = max_run_reg;
    end
    if (write_counter == '1) begin
      write_counter_next = write_counter;
    end else begin
      write_counter_next = write_counter + 1'b1;
    end
  end

  // Links between cells. Every entry moves one place down the chain; the
  // entry that was hit leaves a hole behind it, since it moves to the head.
  always_comb begin
    link_valid[0]   = 1'b1;
    link_address[0] = write_address;
    link_count[0]   = run_next;
    for (int k = 1; k < WINDOW; k++) begin
      link_valid[k]   = status[k-1].valid && !status[k-1].match;
      link_address[k] = cell_address[k-1];
      link_count[k]   = cell_count[k-1];
    end
  end

  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    rwwt_cell #(
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .advance      (accept),
      .probe        (write_address),
      .link_valid   (link_valid[g]),
      .link_address (link_address[g]),
      .link_count   (link_count[g]),
      .status       (status[g]),
      .slot_address (cell_address[g]),
      .slot_count   (cell_count[g])
    );
  end

  // Running totals.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_run_reg   <= '0;
      write_counter <= '0;
    end else if (accept) begin
      max_run_reg   <= max_run_next;
      write_counter <= write_counter_next;
    end
  end

  // Result register: it is loaded with every accepted word and emptied
  // once its word has been taken downstream.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      address_hit <= hit;
      run_count   <= OUT_W'(run_next);
      max_run     <= OUT_W'(max_run_next);
      write_total <= OUT_W'(write_counter_next);
    end
  end

  // An address is never held in two cells at once.
  `RWWT_ASSERT_ALWAYS(a_single_match, clk, $onehot0(match_vec), "address held by more than one cell")

  // Every accepted word leaves its address tracked at the head of the chain.
  `RWWT_ASSERT(a_head_filled, clk, rst, accept |=> status[0].valid, "head cell empty after a write")

  // A first write always reports a run of one.
  `RWWT_ASSERT(a_miss_run_one, clk, rst, (out_valid && !address_hit) |-> (run_count == OUT_W'(1)), "miss with run count other than one")

  // The write total never goes backwards.
  `RWWT_ASSERT(a_total_monotonic, clk, rst, 1'b1 |=> (write_counter >= $past(write_counter)), "write total decreased")

endmodule
